/* rtl/core/clti_pkg.sv */
// Shared types and constants for the clamped table interpolator.
`default_nettype none

package clti_pkg;

   localparam int DATA_W      = 16;
   localparam int ENTRY_IDX_W = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   typedef logic signed [DATA_W-1:0] q88_type;
   typedef logic signed [DATA_W-1:0] q412_type;
   typedef logic        [DATA_W-1:0] uq88_type;

   // item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MASS_OFFSET   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_BIN_WIDTH = 1'b1;

   localparam q88_type  MASS_OFFSET_RESET   = 16'sd0;
   localparam uq88_type INV_BIN_WIDTH_RESET = 16'd256;

endpackage

`default_nettype wire

/* rtl/core/clti_channels.sv */
// Valid/ready channel interfaces for request and response items.
`default_nettype none

interface clti_req_if;
   import clti_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   kind;
   logic [ENTRY_IDX_W-1:0] entry_index;
   q88_type                bin_start;
   q412_type               bin_ratio;
   q88_type                log_mass;

   modport source (output valid, kind, entry_index, bin_start, bin_ratio, log_mass,
                   input ready);
   modport sink   (input valid, kind, entry_index, bin_start, bin_ratio, log_mass,
                   output ready);
endinterface

interface clti_rsp_if;
   import clti_pkg::*;

   logic     valid;
   logic     ready;
   q412_type ratio;
   logic     bad_ratio;

   modport source (output valid, ratio, bad_ratio, input ready);
   modport sink   (input valid, ratio, bad_ratio, output ready);
endinterface

`default_nettype wire

/* rtl/core/clamped_table_linear_interpolator_top.sv */
// Clamped piecewise-linear table interpolator: knot memory, scan sequencer, datapath.
//
// req channel carries two kinds of items. A load writes bin_start/bin_ratio into
// slot entry_index (slots at or beyond TABLE_ENTRIES are dropped) and returns
// nothing. A query returns one rsp item: the first or last knot ratio when the
// log mass lies outside the knots, else a linear interpolation, saturated to
// Q4.12, with bad_ratio set when the interpolated value is zero or negative.
// csr_* writes mass_offset (index 0) and inverse_bin_width (index 1); write
// only while no query is in flight.
// A load leaves the sequencer idle. A query checks the first knot, then the last,
// for the clamped cases; an interpolated one then scans knots 1 .. TABLE_ENTRIES-1
// until the log mass is at or below a knot or the last knot is reached. The scan
// reads the knot memory one entry per cycle, then two multiply stages and a
// round/saturate stage follow. One query is worked at a time; req is ready again
// in the same cycle that its result shows in the output register. The output
// register lets a new item be taken while the previous result waits; a finished
// query stalls in its last state while rsp is held by the receiver.
// Reset restores the csr registers to their reset values and empties the output
// register. The knot memory is not cleared: load every slot before querying.
`default_nettype none

module clamped_table_linear_interpolator_top #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   clti_req_if.sink                          req,
   clti_rsp_if.source                        rsp,
   input  logic                              csr_we,
   input  logic [clti_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [clti_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import clti_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(0);
   localparam logic [IDX_W-1:0] SCAN_IDX0 = IDX_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD0,
      ST_RDLAST,
      ST_SCAN,
      ST_MUL1,
      ST_MUL2,
      ST_RND,
      ST_DONE
   } state_type;

   // knot memory: {bin_start, bin_ratio}
   logic [2*DATA_W-1:0] knot_mem [TABLE_ENTRIES];
   logic [2*DATA_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                mem_we;

   state_type   state_ff, state_in;
   q88_type     offset_ff;
   uq88_type    ibw_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   q412_type    rsp_ratio_ff, rsp_ratio_in;
   logic        rsp_bad_ff, rsp_bad_in;

   q88_type            q_mass_ff, q_mass_in;
   logic signed [16:0] prev_knot_ff, prev_knot_in;
   q412_type           prev_ratio_ff, prev_ratio_in;
   logic [IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic signed [16:0] dr_ff, dr_in;
   logic [16:0]        dm_ff, dm_in;
   logic signed [33:0] p1_ff, p1_in;
   logic signed [51:0] p2_ff, p2_in;
   q412_type           res_ff, res_in;
   logic               bad_ff, bad_in;

   q88_type            rd_mass;
   q412_type           rd_ratio;
   logic signed [16:0] rd_knot;
   logic signed [16:0] q_mass17;
   logic signed [17:0] dm_full;
   logic signed [51:0] p2_biased;
   logic signed [35:0] rnd;
   logic signed [36:0] sum;
   logic               req_xfer;
   logic               stop_scan;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_xfer  = req.valid && req.ready;
   assign mem_we    = req_xfer && (req.kind == KIND_LOAD)
                      && (32'(req.entry_index) < TABLE_ENTRIES);

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.ratio     = rsp_ratio_ff;
   assign rsp.bad_ratio = rsp_bad_ff;

   assign rd_mass  = rd_data_ff[2*DATA_W-1:DATA_W];
   assign rd_ratio = rd_data_ff[DATA_W-1:0];
   assign rd_knot  = {rd_mass[15], rd_mass} + {offset_ff[15], offset_ff};
   assign q_mass17 = {q_mass_ff[15], q_mass_ff};
   assign dm_full  = {q_mass17[16], q_mass17} - {prev_knot_ff[16], prev_knot_ff};
   assign stop_scan = (scan_idx_ff == LAST_IDX) || (q_mass17 <= rd_knot);

   // round half up to Q.12, then add the lower knot ratio
   assign p2_biased = p2_ff + 52'sd32768;
   assign rnd       = p2_biased[51:16];
   assign sum       = {{21{prev_ratio_ff[15]}}, prev_ratio_ff} + {rnd[35], rnd};

   always_comb begin
      case (state_ff)
         ST_RD0:    rd_addr = LAST_IDX;
         ST_RDLAST: rd_addr = SCAN_IDX0;
         ST_SCAN:   rd_addr = (scan_idx_ff == LAST_IDX) ? scan_idx_ff
                                                        : scan_idx_ff + 1'b1;
         default:   rd_addr = FIRST_IDX;
      endcase
   end

   // loads only land while idle and never with a query transfer, so no read that a query uses overlaps a write
   always_ff @(posedge clock) begin
      if (mem_we) begin
         knot_mem[IDX_W'(req.entry_index)] <= {req.bin_start, req.bin_ratio};
      end
      rd_data_ff <= knot_mem[rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_ratio_in  = rsp_ratio_ff;
      rsp_bad_in    = rsp_bad_ff;
      q_mass_in     = q_mass_ff;
      prev_knot_in  = prev_knot_ff;
      prev_ratio_in = prev_ratio_ff;
      scan_idx_in   = scan_idx_ff;
      dr_in         = dr_ff;
      dm_in         = dm_ff;
      p1_in         = p1_ff;
      p2_in         = p2_ff;
      res_in        = res_ff;
      bad_in        = bad_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req.kind == KIND_QUERY)) begin
               q_mass_in = req.log_mass;
               state_in  = ST_RD0;
            end
         end
         ST_RD0: begin
            if (q_mass17 <= rd_knot) begin
               res_in   = rd_ratio;
               bad_in   = 1'b0;
               state_in = ST_DONE;
            end else begin
               prev_knot_in  = rd_knot;
               prev_ratio_in = rd_ratio;
               state_in      = ST_RDLAST;
            end
         end
         ST_RDLAST: begin
            if (q_mass17 >= rd_knot) begin
               res_in   = rd_ratio;
               bad_in   = 1'b0;
               state_in = ST_DONE;
            end else begin
               scan_idx_in = SCAN_IDX0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stop_scan) begin
               dr_in    = {rd_ratio[15], rd_ratio} - {prev_ratio_ff[15], prev_ratio_ff};
               dm_in    = dm_full[16:0];
               state_in = ST_MUL1;
            end else begin
               prev_knot_in  = rd_knot;
               prev_ratio_in = rd_ratio;
               scan_idx_in   = scan_idx_ff + 1'b1;
            end
         end
         ST_MUL1: begin
            p1_in    = dr_ff * $signed({1'b0, ibw_ff});
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            p2_in    = p1_ff * $signed({1'b0, dm_ff});
            state_in = ST_RND;
         end
         ST_RND: begin
            bad_in = sum[36] || (sum == 37'sd0);
            if (sum > 37'sd32767) begin
               res_in = 16'sh7fff;
            end else if (sum < -37'sd32768) begin
               res_in = 16'sh8000;
            end else begin
               res_in = sum[15:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ratio_in = res_ff;
               rsp_bad_in   = bad_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         offset_ff    <= MASS_OFFSET_RESET;
         ibw_ff       <= INV_BIN_WIDTH_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MASS_OFFSET:   offset_ff <= csr_wdata;
               CSR_INV_BIN_WIDTH: ibw_ff    <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ratio_ff  <= rsp_ratio_in;
      rsp_bad_ff    <= rsp_bad_in;
      q_mass_ff     <= q_mass_in;
      prev_knot_ff  <= prev_knot_in;
      prev_ratio_ff <= prev_ratio_in;
      scan_idx_ff   <= scan_idx_in;
      dr_ff         <= dr_in;
      dm_ff         <= dm_in;
      p1_ff         <= p1_in;
      p2_ff         <= p2_in;
      res_ff        <= res_in;
      bad_ff        <= bad_in;
   end

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req.kind == KIND_LOAD)) |=> (state_ff == ST_IDLE))
      else $error("load transfer started a query");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside the finish state");

   a_bad_nonpositive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_ratio_ff[15] || (rsp_ratio_ff == 16'sd0)))
      else $error("bad_ratio set on a positive ratio");

   a_scan_past_first: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_idx_ff != FIRST_IDX))
      else $error("scan index reached the first knot");

endmodule

`default_nettype wire
